/* rtl/core/ugbm_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-16 grapheme boundary marker package
// Shared types, constants and classification functions for the marker unit.
// ----------------------------------------------------------------------------
package ugbm_pkg;

  localparam int POSITION_BITS = 16;
  localparam int UNIT_W        = 16;
  localparam int POS_OUT_W     = 16;
  localparam int CP_W          = 21;
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);
  localparam int QCW           = $clog2(QDEPTH + 1);

  localparam logic [UNIT_W-1:0]        ZWJ_UNIT     = 16'h200D;
  localparam logic [CP_W-1:0]          SUPP_BASE    = 21'h10000;
  localparam logic [POSITION_BITS-1:0] POS_MAX      = {POSITION_BITS{1'b1}};

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [UNIT_W-1:0]    unit_out;
    logic [POS_OUT_W-1:0] unit_position;
    logic                 starts_cluster;
    logic                 last_of_text;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_IN,
    PH_RI1,
    PH_JOIN
  } phase_t;

  typedef enum logic [1:0] {
    HK_NONE,
    HK_LEAD,
    HK_ZWJ
  } hold_t;

  typedef struct packed {
    logic   starts;
    phase_t phase;
  } cls_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  function automatic logic is_lead(input logic [UNIT_W-1:0] u);
    return u >= 16'hD800 && u <= 16'hDBFF;
  endfunction

  function automatic logic is_trail(input logic [UNIT_W-1:0] u);
    return u >= 16'hDC00 && u <= 16'hDFFF;
  endfunction

  function automatic logic is_ri(input logic [CP_W-1:0] cp);
    return cp >= 21'h1F1E6 && cp <= 21'h1F1FF;
  endfunction

  function automatic logic is_extender(input logic [CP_W-1:0] cp);
    return (cp >= 21'h00300 && cp <= 21'h0036F) ||
           (cp >= 21'h01AB0 && cp <= 21'h01AFF) ||
           (cp >= 21'h01DC0 && cp <= 21'h01DFF) ||
           (cp >= 21'h020D0 && cp <= 21'h020FF) ||
           (cp >= 21'h0FE20 && cp <= 21'h0FE2F) ||
           (cp >= 21'h0FE00 && cp <= 21'h0FE0F) ||
           (cp >= 21'hE0100 && cp <= 21'hE01EF) ||
           (cp >= 21'h1F3FB && cp <= 21'h1F3FF);
  endfunction

  function automatic cls_t classify(input logic [CP_W-1:0] cp, input phase_t ph);
    cls_t res;
    res.starts = 1'b1;
    res.phase  = is_ri(cp) ? PH_RI1 : PH_IN;
    case (ph)
      PH_IN: begin
        if (is_extender(cp)) begin
          res.starts = 1'b0;
          res.phase  = PH_IN;
        end
      end
      PH_RI1: begin
        if (is_ri(cp)) begin
          res.starts = 1'b0;
          res.phase  = PH_START;
        end
      end
      PH_JOIN: begin
        res.starts = 1'b0;
        res.phase  = PH_IN;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic pos_t sat_inc(input pos_t p);
    return (p == POS_MAX) ? p : p + pos_t'(1);
  endfunction

endpackage

/* rtl/core/ugbm_front.sv */
// ----------------------------------------------------------------------------
// Grapheme boundary marker front end
// Accepts code units, pairs surrogates, classifies code points and hands up
// to two result words per accepted unit to the result queue.
// ----------------------------------------------------------------------------
module ugbm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ugbm_pkg::in_item_t in_data,
  output ugbm_pkg::push_t    push
);
  import ugbm_pkg::*;

  hold_t             hold_r, hold_nxt;
  logic [UNIT_W-1:0] held_r, held_nxt;
  phase_t            phase_r, phase_nxt;
  pos_t              pos_r, pos_nxt;

  logic              accept;
  logic [UNIT_W-1:0] u;
  logic              eot;
  pos_t              pos_b;
  pos_t              pos_c;
  logic [CP_W-1:0]   first_cp;
  cls_t              cls_first;
  cls_t              cls_unit;
  phase_t            ph_mid;
  logic              pair;
  logic              held_emit;
  logic              unit_emit;
  out_item_t         unit_item;

  assign accept = in_valid & in_ready;
  assign u      = in_data.code_unit;
  assign eot    = in_data.end_of_text;
  assign pos_b  = sat_inc(pos_r);
  assign pos_c  = sat_inc(pos_b);
  assign pair   = (hold_r == HK_LEAD) && is_trail(u);

  assign first_cp  = pair ? ({1'b0, held_r[9:0], u[9:0]} + SUPP_BASE) : CP_W'(held_r);
  assign cls_first = classify(first_cp, phase_r);
  assign held_emit = (hold_r == HK_LEAD) || (hold_r == HK_ZWJ);
  assign ph_mid    = (hold_r == HK_LEAD) ? cls_first.phase : phase_r;
  assign cls_unit  = classify(CP_W'(u), ph_mid);

  always_comb begin
    hold_nxt  = HK_NONE;
    held_nxt  = '0;
    phase_nxt = ph_mid;
    unit_emit = 1'b0;
    if (pair) begin
      phase_nxt = cls_first.phase;
    end else if (is_lead(u) && !eot) begin
      hold_nxt = HK_LEAD;
      held_nxt = u;
    end else if (u == ZWJ_UNIT && ph_mid == PH_IN && !eot) begin
      hold_nxt  = HK_ZWJ;
      held_nxt  = u;
      phase_nxt = PH_JOIN;
    end else begin
      unit_emit = 1'b1;
      phase_nxt = cls_unit.phase;
    end
    pos_nxt = pos_r;
    if (pair) begin
      pos_nxt = pos_c;
    end else if (held_emit && unit_emit) begin
      pos_nxt = pos_c;
    end else if (held_emit || unit_emit) begin
      pos_nxt = pos_b;
    end
    if (eot) begin
      hold_nxt  = HK_NONE;
      held_nxt  = '0;
      phase_nxt = PH_START;
      pos_nxt   = '0;
    end
  end

  always_comb begin
    unit_item.unit_out       = u;
    unit_item.unit_position  = held_emit ? POS_OUT_W'(pos_b) : POS_OUT_W'(pos_r);
    unit_item.starts_cluster = cls_unit.starts;
    unit_item.last_of_text   = eot;

    push.r0.unit_out       = held_r;
    push.r0.unit_position  = POS_OUT_W'(pos_r);
    push.r0.starts_cluster = (hold_r == HK_LEAD) ? cls_first.starts : 1'b0;
    push.r0.last_of_text   = 1'b0;

    push.r1.unit_out       = u;
    push.r1.unit_position  = POS_OUT_W'(pos_b);
    push.r1.starts_cluster = 1'b0;
    push.r1.last_of_text   = eot;

    push.cnt = 2'd0;
    if (accept) begin
      if (pair) begin
        push.cnt = 2'd2;
      end else if (held_emit) begin
        push.r1  = unit_item;
        push.cnt = unit_emit ? 2'd2 : 2'd1;
      end else if (unit_emit) begin
        push.r0  = unit_item;
        push.cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= HK_NONE;
      held_r  <= '0;
      phase_r <= PH_START;
      pos_r   <= '0;
    end else if (accept) begin
      hold_r  <= hold_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

/* rtl/core/ugbm_queue.sv */
// ----------------------------------------------------------------------------
// Grapheme boundary marker result queue
// Short queue that takes up to two result words a cycle from the front end
// and delivers one word a cycle on the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module ugbm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  ugbm_pkg::push_t     push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output ugbm_pkg::out_item_t out_data
);
  import ugbm_pkg::*;

  out_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             pop;

  assign space_ok  = count_r <= QCW'(QDEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid & out_ready;

  assign wp_nxt    = wp_r + QAW'(push.cnt);
  assign rp_nxt    = rp_r + QAW'(pop);
  assign count_nxt = count_r + QCW'(push.cnt) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + QAW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/core/utf16_grapheme_boundary_marker_unit.sv */
// ----------------------------------------------------------------------------
// UTF-16 grapheme boundary marker unit
// Echoes each UTF-16 code unit with its offset and a cluster start flag.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_data   (code_unit, end_of_text)
//   out      out_valid / out_ready out_data  (unit_out, unit_position,
//                                             starts_cluster, last_of_text)
//
// One code unit is accepted every cycle while the four-word result queue has
// room for two words; results leave at one word a cycle while out_ready holds.
// A held lead surrogate or joiner is released with the next unit, so one
// unit gives zero, one or two words. Reset is synchronous and clears the
// hold, phase, position and queue pointers. Either side may stall freely.
// ----------------------------------------------------------------------------
module utf16_grapheme_boundary_marker_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ugbm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ugbm_pkg::out_item_t out_data
);
  import ugbm_pkg::*;

  push_t push;

  ugbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push)
  );

  ugbm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
